[rtl/core/tensor_element_to_float32_unit_macros.svh]
// Assertion macros used by the checker file te2f_checker.sv.
`ifndef TENSOR_ELEMENT_TO_FLOAT32_UNIT_MACROS_SVH
`define TENSOR_ELEMENT_TO_FLOAT32_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TE2F_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TE2F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/te2f_pkg.sv]
package te2f_pkg;

	typedef enum logic [3:0] {
		SRC_F32  = 4'd0,
		SRC_F16  = 4'd1,
		SRC_BF16 = 4'd2,
		SRC_F64  = 4'd3,
		SRC_I64  = 4'd4,
		SRC_I32  = 4'd5,
		SRC_I16  = 4'd6,
		SRC_I8   = 4'd7,
		SRC_U8   = 4'd8,
		SRC_BOOL = 4'd9,
		SRC_U16  = 4'd10,
		SRC_U32  = 4'd11,
		SRC_U64  = 4'd12
	} src_type_t;

	localparam logic [31:0] F32_INF   = 32'h7F80_0000;
	localparam logic [31:0] F32_ONE   = 32'h3F80_0000;
	localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
	localparam int          EXP_W     = 12;

	typedef logic signed [EXP_W-1:0] exp_t;

endpackage

[rtl/core/tensor_element_to_float32_unit.sv]
// Converts a stream of tensor elements of one configured source type into IEEE 754 binary32
// bit patterns, one element per clock cycle when the output is not stalled. The source type
// is held in a 4-bit register written through the cfg channel; the user writes it only while
// the stream is idle, as the block does not enforce this (codes: 0 F32, 1 F16, 2 BF16, 3 F64,
// 4..7 I64/I32/I16/I8, 8 U8, 9 BOOL, 10 U16, 11 U32, 12 U64; other codes give zero). Each
// element passes through a five-stage pipeline (decode, leading-one search, shift amount,
// alignment shift, round and pack), and its result is presented on m_tdata from the output
// register of the last stage. The pipeline moves as a whole: s_tready follows the output
// side, and a stall holds every stage in place.
module tensor_element_to_float32_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: source type code.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// Input stream. tdata: [63:0] raw_bits.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tlast,   // last_in
	// Output stream. tdata: [31:0] result_bits.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast    // last_out
);
	import te2f_pkg::*;

	logic [3:0] src_q;
	logic       adv;

	// The configuration register is always ready to take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_F32;
		end else if (cfg_valid) begin
			src_q <= cfg_data;
		end
	end

	// The whole pipeline advances whenever the output register is free or being drained.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ------------------------------------------------------------------
	// Stage 1: decode into either a finished pattern or sign, significand, exponent.
	// ------------------------------------------------------------------
	logic        dir_c;
	logic [31:0] res_c;
	logic        sgn_c;
	logic [63:0] sig_c;
	exp_t        exp_c;

	logic [63:0] ext_c;
	logic        neg_c;

	always_comb begin
		dir_c = 1'b1;
		res_c = 32'd0;
		sgn_c = 1'b0;
		sig_c = 64'd0;
		exp_c = '0;
		ext_c = 64'd0;
		neg_c = 1'b0;
		unique case (src_q)
			SRC_F32: res_c = s_tdata[31:0];
			SRC_BF16: res_c = {s_tdata[15:0], 16'd0};
			SRC_BOOL: res_c = (s_tdata[7:0] != 8'd0) ? F32_ONE : 32'd0;
			SRC_F16: begin
				sgn_c = s_tdata[15];
				if (s_tdata[14:10] == 5'h1F) begin
					res_c = {s_tdata[15], 31'd0} | F32_INF | {9'd0, s_tdata[9:0], 13'd0};
				end else if (s_tdata[14:0] == 15'd0) begin
					res_c = {s_tdata[15], 31'd0};
				end else if (s_tdata[14:10] == 5'd0) begin
					// Subnormal half: man * 2^-24, normalized later by the packer.
					dir_c = 1'b0;
					sig_c = {54'd0, s_tdata[9:0]};
					exp_c = -exp_t'(24);
				end else begin
					dir_c = 1'b0;
					sig_c = {53'd0, 1'b1, s_tdata[9:0]};
					exp_c = exp_t'({7'd0, s_tdata[14:10]}) - exp_t'(25);
				end
			end
			SRC_F64: begin
				sgn_c = s_tdata[63];
				if (s_tdata[62:52] == 11'h7FF) begin
					if (s_tdata[51:0] == 52'd0) begin
						res_c = {s_tdata[63], 31'd0} | F32_INF;
					end else begin
						res_c = {s_tdata[63], 31'd0} | F32_QNAN | {9'd0, s_tdata[51:29]};
					end
				end else if (s_tdata[62:0] == 63'd0) begin
					res_c = {s_tdata[63], 31'd0};
				end else if (s_tdata[62:52] == 11'd0) begin
					dir_c = 1'b0;
					sig_c = {12'd0, s_tdata[51:0]};
					exp_c = -exp_t'(1074);
				end else begin
					dir_c = 1'b0;
					sig_c = {11'd0, 1'b1, s_tdata[51:0]};
					exp_c = exp_t'({1'b0, s_tdata[62:52]}) - exp_t'(1075);
				end
			end
			SRC_I64, SRC_I32, SRC_I16, SRC_I8,
			SRC_U8, SRC_U16, SRC_U32, SRC_U64: begin
				unique case (src_q)
					SRC_I64: ext_c = s_tdata;
					SRC_I32: ext_c = {{32{s_tdata[31]}}, s_tdata[31:0]};
					SRC_I16: ext_c = {{48{s_tdata[15]}}, s_tdata[15:0]};
					SRC_I8:  ext_c = {{56{s_tdata[7]}}, s_tdata[7:0]};
					SRC_U8:  ext_c = {56'd0, s_tdata[7:0]};
					SRC_U16: ext_c = {48'd0, s_tdata[15:0]};
					SRC_U32: ext_c = {32'd0, s_tdata[31:0]};
					default: ext_c = s_tdata;
				endcase
				neg_c = ext_c[63] && (src_q == SRC_I64 || src_q == SRC_I32 ||
					src_q == SRC_I16 || src_q == SRC_I8);
				sgn_c = neg_c;
				sig_c = neg_c ? (64'd0 - ext_c) : ext_c;
				// Integer zero always gives +0.0.
				dir_c = (sig_c == 64'd0);
			end
			default: res_c = 32'd0;
		endcase
	end

	logic        v_s1, dir_s1, sgn_s1, last_s1;
	logic [31:0] res_s1;
	logic [63:0] sig_s1;
	exp_t        exp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s1  <= dir_c;
			res_s1  <= res_c;
			sgn_s1  <= sgn_c;
			sig_s1  <= sig_c;
			exp_s1  <= exp_c;
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: position of the leading one.
	// ------------------------------------------------------------------
	logic [5:0] msb_c;

	always_comb begin
		msb_c = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (sig_s1[i]) begin
				msb_c = 6'(i);
			end
		end
	end

	logic        v_s2, dir_s2, sgn_s2, last_s2;
	logic [31:0] res_s2;
	logic [63:0] sig_s2;
	exp_t        exp_s2;
	logic [5:0]  msb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s2  <= dir_s1;
			res_s2  <= res_s1;
			sgn_s2  <= sgn_s1;
			sig_s2  <= sig_s1;
			exp_s2  <= exp_s1;
			msb_s2  <= msb_c;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: shift amount. It is the larger of what normalization needs and what the
	// subnormal floor needs; the biased exponent of the lowest kept bit follows from it.
	// ------------------------------------------------------------------
	exp_t sn_c, sf_c, sh_c, bias_c;

	always_comb begin
		sn_c   = exp_t'({6'd0, msb_s2}) - exp_t'(23);
		sf_c   = -exp_t'(149) - exp_s2;
		sh_c   = (sf_c > sn_c) ? sf_c : sn_c;
		bias_c = exp_s2 + sh_c + exp_t'(149);
	end

	logic        v_s3, dir_s3, sgn_s3, last_s3;
	logic [31:0] res_s3;
	logic [63:0] sig_s3;
	exp_t        sh_s3, bias_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s3  <= dir_s2;
			res_s3  <= res_s2;
			sgn_s3  <= sgn_s2;
			sig_s3  <= sig_s2;
			sh_s3   <= sh_c;
			bias_s3 <= bias_c;
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: alignment shift with guard and sticky bits.
	// ------------------------------------------------------------------
	logic [23:0] q_c;
	logic        rnd_c, stk_c, zero_c;
	logic [6:0]  rsh_c;
	logic [63:0] qw_c;
	exp_t        lsh_c;

	always_comb begin
		q_c    = 24'd0;
		rnd_c  = 1'b0;
		stk_c  = 1'b0;
		zero_c = 1'b0;
		rsh_c  = 7'd0;
		qw_c   = 64'd0;
		lsh_c  = -sh_s3;
		if (sh_s3 <= exp_t'(0)) begin
			qw_c = sig_s3 << lsh_c[4:0];
			q_c  = qw_c[23:0];
		end else if (sh_s3 > exp_t'(64)) begin
			// Everything lies below half of the smallest subnormal.
			zero_c = 1'b1;
		end else begin
			rsh_c = sh_s3[6:0] - 7'd1;
			qw_c  = (sig_s3 >> rsh_c[5:0]) >> 1;
			q_c   = qw_c[23:0];
			rnd_c = sig_s3[rsh_c[5:0]];
			stk_c = (sig_s3 & ~({64{1'b1}} << rsh_c[5:0])) != 64'd0;
		end
	end

	logic        v_s4, dir_s4, sgn_s4, last_s4, rnd_s4, stk_s4, zero_s4;
	logic [31:0] res_s4;
	logic [23:0] q_s4;
	exp_t        bias_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s4  <= dir_s3;
			res_s4  <= res_s3;
			sgn_s4  <= sgn_s3;
			q_s4    <= q_c;
			rnd_s4  <= rnd_c;
			stk_s4  <= stk_c;
			zero_s4 <= zero_c;
			bias_s4 <= bias_s3;
			last_s4 <= last_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: round to nearest even, pack, saturate to infinity. This is the output register.
	// ------------------------------------------------------------------
	logic [24:0] m_c;
	logic [35:0] fld_c;
	logic [31:0] out_c;

	always_comb begin
		m_c   = {1'b0, q_s4} + {24'd0, rnd_s4 && (stk_s4 || q_s4[0])};
		// A carry out of the significand bumps the exponent through the add.
		fld_c = {1'b0, bias_s4, 23'd0} + {11'd0, m_c};
		if (dir_s4) begin
			out_c = res_s4;
		end else if (zero_s4) begin
			out_c = {sgn_s4, 31'd0};
		end else if (fld_c >= {4'd0, F32_INF}) begin
			out_c = {sgn_s4, 31'd0} | F32_INF;
		end else begin
			out_c = {sgn_s4, fld_c[30:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= out_c;
			m_tlast <= last_s4;
		end
	end

endmodule

[rtl/core/te2f_checker.sv]
`include "tensor_element_to_float32_unit_macros.svh"

module te2f_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result holds its value.
	`TE2F_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// The input side is open whenever the output drains.
	`TE2F_ASSERT_NOW(a_flow, clk, arst_n, m_tready, s_tready)

	// An empty output register never blocks the input.
	`TE2F_ASSERT_NOW(a_empty, clk, arst_n, !m_tvalid, s_tready)

	// Configuration writes are never refused.
	`TE2F_ASSERT_NOW(a_cfg, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind tensor_element_to_float32_unit te2f_checker u_te2f_checker (.*);
